@@ hw/rtl/u2u_pkg.sv @@
// u2u_pkg: shared types and byte-class constants for the UTF-8 to UTF-16 decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package u2u_pkg;

   localparam int BYTE_W = 8;
   localparam int UNIT_W = 16;

   // byte classes
   localparam logic [7:0] LEAD3_LO = 8'he0;
   localparam logic [7:0] LEAD3_HI = 8'hef;
   localparam logic [7:0] LEAD2_LO = 8'hc0;
   localparam logic [7:0] LEAD2_HI = 8'hdf;
   localparam logic [7:0] CONT_LO  = 8'h80;
   localparam logic [7:0] CONT_HI  = 8'hbf;

   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_ONE  = 2'd1;
   localparam logic [1:0] PEND_TWO  = 2'd2;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_in;
      logic              end_of_string;
   } item_type;

   typedef struct packed {
      logic [UNIT_W-1:0] code_unit;
      logic              unit_valid;
      logic              string_done;
      logic              truncated;
   } result_type;

endpackage

@@ hw/rtl/utf8_to_utf16_decoder.sv @@
// utf8_to_utf16_decoder: top level, one UTF-8 byte in per transfer, 16-bit units out.
// Depends on u2u_pkg, u2u_in_stage, u2u_decode, u2u_out_stage.
`timescale 1ns / 1ps

// Gives at most one result per byte. Between the byte's transfer and its result lie
// an input register, then the decode step and the result register. Throughput is one
// byte per cycle while the result side takes every result, and req_tready follows
// rsp_tready within the same cycle. A result comes for every completed nonzero unit
// before the string's zero terminator, and always for a byte with tlast set (rsp_tlast
// high, unit flag low if no unit completed, truncated flag high if the string stopped
// inside a multi-byte sequence).

module utf8_to_utf16_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tlast,   // end_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] code_unit
   output logic [1:0]  rsp_tuser,   // [0] unit_valid, [1] truncated
   output logic        rsp_tlast    // string_done
);
   import u2u_pkg::*;

   item_type   in_item, item;
   logic       item_valid, take, can_load, res_valid;
   result_type res, out_res;

   assign in_item.byte_in       = req_tdata;
   assign in_item.end_of_string = req_tlast;

   assign take = item_valid && can_load;

   u2u_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .item_valid (item_valid),
      .item_take  (take),
      .item       (item)
   );

   u2u_decode u_dec (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   u2u_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (take && res_valid),
      .load_res  (res),
      .can_load  (can_load),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   assign rsp_tdata = out_res.code_unit;
   assign rsp_tuser = {out_res.truncated, out_res.unit_valid};
   assign rsp_tlast = out_res.string_done;

endmodule

@@ hw/rtl/u2u_in_stage.sv @@
// u2u_in_stage: input register holding one accepted byte until the decoder takes it.
// Depends on u2u_pkg.
`timescale 1ns / 1ps

module u2u_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  u2u_pkg::item_type  in_item,
   output logic               item_valid,
   input  logic               item_take,
   output u2u_pkg::item_type  item
);
   import u2u_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign in_ready   = !valid_ff || item_take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
         item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

@@ hw/rtl/u2u_decode.sv @@
// u2u_decode: per-byte decode state (pending count, partial unit, terminated flag)
// and the combinational step that forms a result. Depends on u2u_pkg.
`timescale 1ns / 1ps

module u2u_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  u2u_pkg::item_type   item,
   output logic                res_valid,
   output u2u_pkg::result_type res
);
   import u2u_pkg::*;

   logic [1:0]        pending_ff, pending_in;
   logic [UNIT_W-1:0] acc_ff, acc_in;
   logic              term_ff, term_in;

   logic [UNIT_W-1:0] acc_shift;
   logic [UNIT_W-1:0] unit;
   logic              have_unit;
   logic              emit;

   assign acc_shift = {acc_ff[UNIT_W-7:0], item.byte_in[5:0]};

   always_comb begin
      pending_in = pending_ff;
      acc_in     = acc_ff;
      term_in    = term_ff;
      have_unit  = 1'b0;
      unit       = '0;
      emit       = 1'b0;

      if (pending_ff != PEND_NONE) begin
         acc_in     = acc_shift;
         pending_in = pending_ff - 2'd1;
         if (pending_ff == PEND_ONE) begin
            have_unit = 1'b1;
            unit      = acc_shift;
         end
      end else begin
         case (item.byte_in) inside
            [LEAD3_LO:LEAD3_HI]: begin
               acc_in     = {12'd0, item.byte_in[3:0]};
               pending_in = PEND_TWO;
            end
            [LEAD2_LO:LEAD2_HI]: begin
               acc_in     = {11'd0, item.byte_in[4:0]};
               pending_in = PEND_ONE;
            end
            [CONT_LO:CONT_HI]: begin
               // stray continuation, skipped
            end
            default: begin
               have_unit = 1'b1;
               unit      = {8'd0, item.byte_in};
            end
         endcase
      end

      if (have_unit) begin
         acc_in = '0;
         if (unit == '0) begin
            term_in = 1'b1;
         end else begin
            emit = !term_ff;
         end
      end

      res.code_unit   = emit ? unit : '0;
      res.unit_valid  = emit;
      res.string_done = item.end_of_string;
      res.truncated   = item.end_of_string && (pending_in != PEND_NONE);
      res_valid       = emit || item.end_of_string;

      if (item.end_of_string) begin
         pending_in = PEND_NONE;
         acc_in     = '0;
         term_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= PEND_NONE;
         acc_ff     <= '0;
         term_ff    <= 1'b0;
      end else if (take) begin
         pending_ff <= pending_in;
         acc_ff     <= acc_in;
         term_ff    <= term_in;
      end
   end

   a_clear_at_end: assert property (@(posedge clock) disable iff (reset)
      take && item.end_of_string |=> pending_ff == PEND_NONE && acc_ff == '0 && !term_ff)
      else $error("decode state not cleared after string end");

   a_term_sticky: assert property (@(posedge clock) disable iff (reset)
      take && term_ff && !item.end_of_string |=> term_ff)
      else $error("terminated flag dropped inside a string");

   a_three_byte_head: assert property (@(posedge clock) disable iff (reset)
      pending_ff == PEND_TWO |-> acc_ff[UNIT_W-1:4] == '0)
      else $error("three-byte lead left stray accumulator bits");

   a_no_unit_after_term: assert property (@(posedge clock) disable iff (reset)
      term_ff |-> !res.unit_valid)
      else $error("unit emitted after terminator");

endmodule

@@ hw/rtl/u2u_out_stage.sv @@
// u2u_out_stage: result register toward the response channel.
// Depends on u2u_pkg.
`timescale 1ns / 1ps

module u2u_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  u2u_pkg::result_type load_res,
   output logic                can_load,
   output logic                out_valid,
   input  logic                out_ready,
   output u2u_pkg::result_type out_res
);
   import u2u_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign can_load  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_res   = res_ff;

   always_comb begin
      valid_in = valid_ff && !out_ready;
      res_in   = res_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in   = load_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

endmodule
